>>> rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, opcodes, defaults and the arctangent table of the complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH_DEF   = 32;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Angle accumulator: Q2.30 with sign, wide enough for +/- pi
  localparam int ANG_FRAC = 30;
  localparam int ZW       = 34;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;
  localparam logic [2:0] OP_MOD  = 3'd5;
  localparam logic [2:0] OP_ARG  = 3'd6;
  localparam logic [2:0] OP_EQ   = 3'd7;

  // One-hot operation class, decoded once at the front
  typedef struct packed {
    logic add;
    logic sub;
    logic mul;
    logic div;
    logic conj;
    logic modl;
    logic arg;
    logic eq;
  } cls_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd7;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/cau_if.sv
// ----------------------------------------------------------------------------
// cau_if
// Valid/ready channels for operands and results of the complex ALU.
// ----------------------------------------------------------------------------
interface cau_in_if #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   opcode;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;

  modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic                         is_equal;
  logic                         div_zero;
  logic                         overflow;

  modport source (output valid, res_re, res_im, is_equal, div_zero, overflow, input ready);
  modport sink   (input valid, res_re, res_im, is_equal, div_zero, overflow, output ready);
endinterface

>>> rtl/core/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Accepts operand transfers, decodes the opcode and holds items in a
// two-entry queue for the execution pipeline.
// ----------------------------------------------------------------------------
module cau_front #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  cau_in_if.sink                       operand,
  output logic                         q_valid,
  output cau_pkg::cls_t                q_cls,
  output logic signed [DATA_WIDTH-1:0] q_are,
  output logic signed [DATA_WIDTH-1:0] q_aim,
  output logic signed [DATA_WIDTH-1:0] q_bre,
  output logic signed [DATA_WIDTH-1:0] q_bim,
  input  logic                         q_pop
);

  cau_pkg::cls_t               cls_mem [0:1];
  logic signed [DATA_WIDTH-1:0] are_mem [0:1];
  logic signed [DATA_WIDTH-1:0] aim_mem [0:1];
  logic signed [DATA_WIDTH-1:0] bre_mem [0:1];
  logic signed [DATA_WIDTH-1:0] bim_mem [0:1];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  cau_pkg::cls_t dec;

  always_comb begin
    dec = '0;
    unique case (operand.opcode)
      cau_pkg::OP_ADD:  dec.add  = 1'b1;
      cau_pkg::OP_SUB:  dec.sub  = 1'b1;
      cau_pkg::OP_MUL:  dec.mul  = 1'b1;
      cau_pkg::OP_DIV:  dec.div  = 1'b1;
      cau_pkg::OP_CONJ: dec.conj = 1'b1;
      cau_pkg::OP_MOD:  dec.modl = 1'b1;
      cau_pkg::OP_ARG:  dec.arg  = 1'b1;
      default:          dec.eq   = 1'b1;
    endcase
  end

  assign operand.ready = (cnt != 2'd2);
  assign push          = operand.valid && operand.ready;
  assign q_valid       = (cnt != 2'd0);
  assign q_cls         = cls_mem[rp];
  assign q_are         = are_mem[rp];
  assign q_aim         = aim_mem[rp];
  assign q_bre         = bre_mem[rp];
  assign q_bim         = bim_mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cls_mem[wp] <= dec;
      are_mem[wp] <= operand.a_re;
      aim_mem[wp] <= operand.a_im;
      bre_mem[wp] <= operand.b_re;
      bim_mem[wp] <= operand.b_im;
    end
  end

endmodule

>>> rtl/core/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Execution pipeline: products, sums, then one stage per quotient/root bit
// and CORDIC step, then truncation and saturation into the result register.
// ----------------------------------------------------------------------------
module cau_back #(
  parameter int DATA_WIDTH   = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS    = cau_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = cau_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  cau_pkg::cls_t                q_cls,
  input  logic signed [DATA_WIDTH-1:0] q_are,
  input  logic signed [DATA_WIDTH-1:0] q_aim,
  input  logic signed [DATA_WIDTH-1:0] q_bre,
  input  logic signed [DATA_WIDTH-1:0] q_bim,
  output logic                         q_pop,
  cau_out_if.source                    result
);

  localparam int W   = DATA_WIDTH;
  localparam int P   = 2 * W;
  localparam int S   = 2 * W + 1;
  localparam int CW  = W + 3;
  localparam int ZW  = cau_pkg::ZW;
  localparam int RW  = 3 * W + FRAC_BITS;
  localparam int MW  = 2 * W + 2;
  localparam int NIT = (W > CORDIC_STEPS) ? W : CORDIC_STEPS;
  localparam int L   = NIT + 2;

  logic en;

  // Carried through every stage
  logic                  v     [0:L];
  cau_pkg::cls_t         cls   [0:L];
  logic signed [S-1:0]   dre   [0:L];
  logic signed [S-1:0]   dim   [0:L];
  logic                  eqf   [0:L];
  logic signed [CW-1:0]  cx    [0:L];
  logic signed [CW-1:0]  cy    [0:L];
  logic signed [ZW-1:0]  cz    [0:L];
  logic                  czero [0:L];

  // Product stage
  logic signed [P-1:0] p0, p1, p2, p3, p4, p5;
  // Sum stage
  logic signed [S-1:0] nre, nim;
  logic [P-1:0]        sq;
  // Divider and square root state
  logic                dz    [2:L];
  logic [RW-1:0]       rre   [2:L];
  logic [RW-1:0]       rim   [2:L];
  logic [W-1:0]        qre   [2:L];
  logic [W-1:0]        qim   [2:L];
  logic                ngre  [2:L];
  logic                ngim  [2:L];
  logic                ovre  [2:L];
  logic                ovim  [2:L];
  logic [P-1:0]        dd    [2:L];
  logic [P-1:0]        sn    [2:L];
  logic [P-1:0]        sres  [2:L];

  // Advance everything whenever the result register is free or being drained
  assign en    = !result.valid || result.ready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= L; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[0] <= q_valid;
      for (int i = 1; i <= L; i++) v[i] <= v[i-1];
    end
  end

  // ---- stage 0: products, direct ops, CORDIC pre-rotation
  logic signed [S-1:0]  dre0, dim0;
  logic signed [CW-1:0] x0, y0, xe, ye;
  logic signed [ZW-1:0] z0;
  logic signed [W-1:0]  sqx, sqy;

  always_comb begin
    dre0 = '0;
    dim0 = '0;
    if (q_cls.add) begin
      dre0 = S'(q_are) + S'(q_bre);
      dim0 = S'(q_aim) + S'(q_bim);
    end else if (q_cls.sub) begin
      dre0 = S'(q_are) - S'(q_bre);
      dim0 = S'(q_aim) - S'(q_bim);
    end else if (q_cls.conj) begin
      dre0 = S'(q_are);
      dim0 = -S'(q_aim);
    end
    xe = CW'(q_are);
    ye = CW'(q_aim);
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (q_are < 0) begin
      if (q_aim >= 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = cau_pkg::HALF_PI_Q30;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -cau_pkg::HALF_PI_Q30;
      end
    end
    sqx = q_cls.div ? q_bre : q_are;
    sqy = q_cls.div ? q_bim : q_aim;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls[0]   <= q_cls;
      p0       <= q_are * q_bre;
      p1       <= q_aim * q_bim;
      p2       <= q_are * q_bim;
      p3       <= q_aim * q_bre;
      p4       <= sqx * sqx;
      p5       <= sqy * sqy;
      dre[0]   <= dre0;
      dim[0]   <= dim0;
      eqf[0]   <= (q_are == q_bre) && (q_aim == q_bim);
      cx[0]    <= x0;
      cy[0]    <= y0;
      cz[0]    <= z0;
      czero[0] <= (q_are == 0) && (q_aim == 0);
    end
  end

  // ---- stage 1: sums of products
  always_ff @(posedge clk) begin
    if (en) begin
      cls[1]   <= cls[0];
      eqf[1]   <= eqf[0];
      cx[1]    <= cx[0];
      cy[1]    <= cy[0];
      cz[1]    <= cz[0];
      czero[1] <= czero[0];
      if (cls[0].mul) begin
        dre[1] <= S'(p0) - S'(p1);
        dim[1] <= S'(p2) + S'(p3);
      end else begin
        dre[1] <= dre[0];
        dim[1] <= dim[0];
      end
      nre <= S'(p0) + S'(p1);
      nim <= S'(p3) - S'(p2);
      sq  <= P'($unsigned(p4)) + P'($unsigned(p5));
    end
  end

  // ---- stage 2: divider and root setup
  logic [P-1:0] mre, mim;
  logic [RW-1:0] xre, xim, dtop;

  always_comb begin
    mre  = (nre < 0) ? P'(-nre) : P'(nre);
    mim  = (nim < 0) ? P'(-nim) : P'(nim);
    xre  = RW'(mre) << FRAC_BITS;
    xim  = RW'(mim) << FRAC_BITS;
    dtop = RW'(sq) << W;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls[2]   <= cls[1];
      dre[2]   <= dre[1];
      dim[2]   <= dim[1];
      eqf[2]   <= eqf[1];
      cx[2]    <= cx[1];
      cy[2]    <= cy[1];
      cz[2]    <= cz[1];
      czero[2] <= czero[1];
      dz[2]    <= (sq == '0);
      rre[2]   <= xre;
      rim[2]   <= xim;
      ovre[2]  <= (xre >= dtop);
      ovim[2]  <= (xim >= dtop);
      ngre[2]  <= (nre < 0);
      ngim[2]  <= (nim < 0);
      qre[2]   <= '0;
      qim[2]   <= '0;
      dd[2]    <= sq;
      sn[2]    <= sq;
      sres[2]  <= '0;
    end
  end

  // ---- iteration stages: each does at most one quotient bit, one root bit and one CORDIC step
  for (genvar i = 0; i < NIT; i++) begin : g_it
    localparam int D = 2 + i;
    localparam int K = (i < W) ? (W - 1 - i) : 0;

    logic [RW-1:0]        dsh;
    logic [RW-1:0]        nrr, nri;
    logic [W-1:0]         nqr, nqi;
    logic [P-1:0]         sbit, nsn, nsr;
    logic [P:0]           strial;
    logic signed [CW-1:0] nx, ny, dx, dy;
    logic signed [ZW-1:0] nz, ang;

    always_comb begin
      dsh    = RW'(dd[D]) << K;
      nrr    = rre[D];
      nri    = rim[D];
      nqr    = qre[D];
      nqi    = qim[D];
      sbit   = P'(1) << (2 * K);
      strial = {1'b0, sres[D]} + {1'b0, sbit};
      nsn    = sn[D];
      nsr    = sres[D];
      if (i < W) begin
        if (rre[D] >= dsh) begin
          nrr    = rre[D] - dsh;
          nqr[K] = 1'b1;
        end
        if (rim[D] >= dsh) begin
          nri    = rim[D] - dsh;
          nqi[K] = 1'b1;
        end
        if ({1'b0, sn[D]} >= strial) begin
          nsn = sn[D] - strial[P-1:0];
          nsr = (sres[D] >> 1) + sbit;
        end else begin
          nsr = sres[D] >> 1;
        end
      end
      dx  = cy[D] >>> i;
      dy  = cx[D] >>> i;
      ang = cau_pkg::atan_q30(i);
      nx  = cx[D];
      ny  = cy[D];
      nz  = cz[D];
      if (i < CORDIC_STEPS) begin
        if (cy[D] > 0) begin
          nx = cx[D] + dx;
          ny = cy[D] - dy;
          nz = cz[D] + ang;
        end else begin
          nx = cx[D] - dx;
          ny = cy[D] + dy;
          nz = cz[D] - ang;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cls[D+1]   <= cls[D];
        dre[D+1]   <= dre[D];
        dim[D+1]   <= dim[D];
        eqf[D+1]   <= eqf[D];
        czero[D+1] <= czero[D];
        dz[D+1]    <= dz[D];
        ngre[D+1]  <= ngre[D];
        ngim[D+1]  <= ngim[D];
        ovre[D+1]  <= ovre[D];
        ovim[D+1]  <= ovim[D];
        dd[D+1]    <= dd[D];
        cx[D+1]    <= nx;
        cy[D+1]    <= ny;
        cz[D+1]    <= nz;
        rre[D+1]   <= nrr;
        rim[D+1]   <= nri;
        qre[D+1]   <= nqr;
        qim[D+1]   <= nqi;
        sn[D+1]    <= nsn;
        sres[D+1]  <= nsr;
      end
    end
  end

  // ---- final: sign/magnitude select, truncation and saturation
  function automatic logic [W:0] sat(input logic ng, input logic [MW-1:0] m);
    logic [MW-1:0] top;
    logic [W:0]    r;
    top = MW'(1) << (W - 1);
    if (ng) begin
      if (m > top) r = {1'b1, top[W-1:0]};
      else         r = {1'b0, W'(MW'(0) - m)};
    end else begin
      if (m > top - MW'(1)) r = {1'b1, W'(top - MW'(1))};
      else                  r = {1'b0, m[W-1:0]};
    end
    return r;
  endfunction

  cau_pkg::cls_t       fc;
  logic                nre_f, nim_f;
  logic [MW-1:0]       mre_f, mim_f;
  logic [W:0]          sre, sim;
  logic signed [ZW-1:0] zf;

  always_comb begin
    fc    = cls[L];
    nre_f = 1'b0;
    nim_f = 1'b0;
    mre_f = '0;
    mim_f = '0;
    zf    = cz[L];
    if (fc.add || fc.sub || fc.conj || fc.mul) begin
      nre_f = dre[L] < 0;
      nim_f = dim[L] < 0;
      mre_f = (dre[L] < 0) ? MW'(-dre[L]) : MW'(dre[L]);
      mim_f = (dim[L] < 0) ? MW'(-dim[L]) : MW'(dim[L]);
      if (fc.mul) begin
        mre_f = mre_f >> FRAC_BITS;
        mim_f = mim_f >> FRAC_BITS;
      end
    end else if (fc.div) begin
      if (!dz[L]) begin
        nre_f = ngre[L];
        nim_f = ngim[L];
        mre_f = ovre[L] ? '1 : MW'(qre[L]);
        mim_f = ovim[L] ? '1 : MW'(qim[L]);
      end
    end else if (fc.modl) begin
      mre_f = MW'(sres[L]);
    end else if (fc.arg) begin
      if (!czero[L]) begin
        nre_f = zf < 0;
        mre_f = MW'((zf < 0) ? -zf : zf) >> (cau_pkg::ANG_FRAC - FRAC_BITS);
      end
    end
    sre = sat(nre_f, mre_f);
    sim = sat(nim_f, mim_f);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= v[L];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.res_re   <= sre[W-1:0];
      result.res_im   <= sim[W-1:0];
      result.is_equal <= fc.eq && eqf[L];
      result.div_zero <= fc.div && dz[L];
      result.overflow <= sre[W] || sim[W];
    end
  end

endmodule

>>> rtl/core/complex_arithmetic_unit.sv
// Path: an accepted item passes the operand queue, the execution stages and
//   the result register; the divider/root or CORDIC, if longer, sets the depth.
// Throughput: one item per cycle unless a result waits untaken; fully pipelined.
// Reset (rst, synchronous): empties the operand queue and drops every item in
//   flight; result.valid is low after reset.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex ALU in signed fixed point: add, sub, mul, div, conj, modulus,
// argument and compare, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH   = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS    = cau_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = cau_pkg::CORDIC_STEPS_DEF
) (
  input logic       clk,
  input logic       rst,
  cau_in_if.sink    operand,
  cau_out_if.source result
);

  // Front/back handoff: the queue head and its pop strobe
  logic                         q_valid;
  cau_pkg::cls_t                q_cls;
  logic signed [DATA_WIDTH-1:0] q_are;
  logic signed [DATA_WIDTH-1:0] q_aim;
  logic signed [DATA_WIDTH-1:0] q_bre;
  logic signed [DATA_WIDTH-1:0] q_bim;
  logic                         q_pop;

  // Front: take operand transfers, decode the opcode, queue the item
  cau_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .operand (operand),
    .q_valid (q_valid),
    .q_cls   (q_cls),
    .q_are   (q_are),
    .q_aim   (q_aim),
    .q_bre   (q_bre),
    .q_bim   (q_bim),
    .q_pop   (q_pop)
  );

  // Back: the arithmetic pipeline; it stalls as a whole only when the
  // result register holds a transfer the consumer has not taken
  cau_back #(
    .DATA_WIDTH   (DATA_WIDTH),
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cls   (q_cls),
    .q_are   (q_are),
    .q_aim   (q_aim),
    .q_bre   (q_bre),
    .q_bim   (q_bim),
    .q_pop   (q_pop),
    .result  (result)
  );

  // Pop only an occupied queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // The queue head holds exactly one operation class
  a_cls_onehot: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> $onehot(q_cls))
    else $error("queued item has no single operation class");

  // A zero denominator forces a clean zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.div_zero |->
      result.res_re == 0 && result.res_im == 0 && !result.overflow)
    else $error("divide by zero result not cleared");

  // A compare carries no arithmetic result
  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.is_equal |->
      result.res_re == 0 && result.res_im == 0 && !result.div_zero)
    else $error("compare result carries data");

endmodule

>>> verif/tb_complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Self-checking bench for the complex ALU. A directed set covers the operand
// extremes and the corner cases of every operation. Random streams follow,
// with idle bursts on both channels. Every result is checked field by field
// against an exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W          = 32;
  localparam int FB         = 16;
  localparam int STEPS      = 16;
  localparam int LATENCY    = 36;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_RANDOM   = 680;
  localparam int N_QUIET    = 60;

  typedef struct {
    logic [2:0]          opcode;
    logic signed [W-1:0] a_re, a_im, b_re, b_im;
  } operands_t;

  typedef struct {
    logic signed [W-1:0] res_re, res_im;
    logic                is_equal, div_zero, overflow;
  } answer_t;

  // Exact Q16.16 complex math with a queue of answers still owed by the DUT
  class alu_scoreboard;
    answer_t owed[$];
    int      mismatches;
    int      checked;
    int      op_count[8];

    // atan(2^-i) in Q2.30, truncated
    longint atan_tab[STEPS] = '{843314856, 497837829, 263043836, 133525158,
      67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
      524287, 262143, 131071, 65535, 32767};

    function logic [W-1:0] clamp(logic signed [127:0] v, int shift, ref bit ovf);
      logic [127:0] mag;
      logic [127:0] top;
      bit           neg;
      neg = v < 0;
      mag = neg ? -v : v;
      mag = mag >> shift;
      top = 128'd1 << (W - 1);
      if (mag == 0) neg = 0;
      if (neg) begin
        if (mag > top) begin
          mag = top;
          ovf = 1;
        end
        return W'(-mag);
      end
      if (mag > top - 1) begin
        mag = top - 1;
        ovf = 1;
      end
      return W'(mag);
    endfunction

    function logic [127:0] root_floor(logic [127:0] n);
      logic [127:0] res;
      logic [127:0] b;
      res = 0;
      b = 128'd1 << 126;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // atan2(y, x) in Q2.30 by vectoring CORDIC with a quadrant pre-rotation
    function longint angle_q30(longint y, longint x);
      longint z;
      longint t;
      longint dx;
      longint dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = cau_pkg::HALF_PI_Q30;
        end else begin
          t = x; x = -y; y = t; z = -cau_pkg::HALF_PI_Q30;
        end
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += atan_tab[i];
        end else begin
          x -= dx; y += dy; z -= atan_tab[i];
        end
      end
      return z;
    endfunction

    function answer_t compute(operands_t o);
      answer_t             r;
      logic signed [127:0] ar, ai, br, bi, vre, vim, den, q;
      int                  sh;
      bit                  ovf;
      ar = o.a_re; ai = o.a_im; br = o.b_re; bi = o.b_im;
      vre = 0; vim = 0; sh = 0; ovf = 0;
      r.is_equal = 0;
      r.div_zero = 0;
      case (o.opcode)
        cau_pkg::OP_ADD: begin
          vre = ar + br; vim = ai + bi;
        end
        cau_pkg::OP_SUB: begin
          vre = ar - br; vim = ai - bi;
        end
        cau_pkg::OP_MUL: begin
          vre = ar * br - ai * bi;
          vim = ar * bi + ai * br;
          sh = FB;
        end
        cau_pkg::OP_DIV: begin
          den = br * br + bi * bi;
          if (den == 0) begin
            r.div_zero = 1;
          end else begin
            // truncate each quotient toward zero
            q = ar * br + ai * bi;
            vre = (q < 0) ? -(((-q) << FB) / den) : ((q << FB) / den);
            q = ai * br - ar * bi;
            vim = (q < 0) ? -(((-q) << FB) / den) : ((q << FB) / den);
          end
        end
        cau_pkg::OP_CONJ: begin
          vre = ar; vim = -ai;
        end
        cau_pkg::OP_MOD: vre = root_floor(ar * ar + ai * ai);
        cau_pkg::OP_ARG: begin
          vre = angle_q30(longint'(o.a_im), longint'(o.a_re));
          sh = cau_pkg::ANG_FRAC - FB;
        end
        default: r.is_equal = (o.a_re == o.b_re) && (o.a_im == o.b_im);
      endcase
      r.res_re = clamp(vre, sh, ovf);
      r.res_im = clamp(vim, sh, ovf);
      r.overflow = ovf;
      return r;
    endfunction

    function void note(operands_t o);
      owed.push_back(compute(o));
      op_count[o.opcode]++;
    endfunction

    function void check(answer_t got);
      answer_t want;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result re=%0d im=%0d",
                                       got.res_re, got.res_im);
        return;
      end
      want = owed.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: result %0d exp re=%0d im=%0d eq=%b dz=%b ov=%b",
                    " got re=%0d im=%0d eq=%b dz=%b ov=%b"},
                   checked, want.res_re, want.res_im, want.is_equal, want.div_zero,
                   want.overflow, got.res_re, got.res_im, got.is_equal, got.div_zero,
                   got.overflow);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  int   idle_cycles;

  cau_in_if  #(.DATA_WIDTH(W)) operand();
  cau_out_if #(.DATA_WIDTH(W)) result();

  alu_scoreboard sb = new();

  complex_arithmetic_unit #(
    .DATA_WIDTH  (W),
    .FRAC_BITS   (FB),
    .CORDIC_STEPS(STEPS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .operand(operand.sink),
    .result (result.source)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Check every result transfer against the oldest owed answer
  always @(posedge clk) begin
    answer_t got;
    if (!rst && result.valid && result.ready) begin
      got.res_re   = result.res_re;
      got.res_im   = result.res_im;
      got.is_equal = result.is_equal;
      got.div_zero = result.div_zero;
      got.overflow = result.overflow;
      sb.check(got);
    end
  end

  // Stall the result side in random bursts; hold ready high once quiet
  initial begin
    int burst;
    result.ready = 1'b0;
    @(negedge clk);
    while (1) begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 11);
        result.ready <= 1'b0;
        repeat (burst) @(negedge clk);
      end else begin
        result.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (operand.valid && operand.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("complex_arithmetic_unit verification failed");
        $finish;
      end
    end
  end

  // Drive one operand transfer; optionally insert an idle burst first.
  // Called at a falling edge, returns at a falling edge.
  task automatic send(operands_t o);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      operand.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    operand.valid  <= 1'b1;
    operand.opcode <= o.opcode;
    operand.a_re   <= o.a_re;
    operand.a_im   <= o.a_im;
    operand.b_re   <= o.b_re;
    operand.b_im   <= o.b_im;
    do @(posedge clk); while (!operand.ready);
    sb.note(o);
    @(negedge clk);
  endtask

  task automatic send_ops(logic [2:0] op, logic signed [W-1:0] ar, logic signed [W-1:0] ai,
                          logic signed [W-1:0] br, logic signed [W-1:0] bi);
    operands_t o;
    o.opcode = op; o.a_re = ar; o.a_im = ai; o.b_re = br; o.b_im = bi;
    send(o);
  endtask

  // Drop valid and hold until every owed answer has come back
  task automatic drain();
    operand.valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2, 3:    return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      4:       return 0;
      5:       return {1'b0, {(W-1){1'b1}}};
      6:       return {1'b1, {(W-1){1'b0}}};
      default: return ($urandom_range(0, 1) ? 1 : -1) <<< FB;
    endcase
  endfunction

  initial begin
    operands_t o;
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = 1 <<< FB;
    quiet = 0;
    rst = 1'b1;
    operand.valid  = 1'b0;
    operand.opcode = cau_pkg::OP_ADD;
    operand.a_re   = '0;
    operand.a_im   = '0;
    operand.b_re   = '0;
    operand.b_im   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: saturation at both ends, divide by zero, argument corners, compare
    send_ops(cau_pkg::OP_ADD,  MAXV, MINV, MAXV, MINV);
    send_ops(cau_pkg::OP_ADD,  -ONE, ONE, ONE, -ONE);
    send_ops(cau_pkg::OP_SUB,  MINV, MAXV, MAXV, MINV);
    send_ops(cau_pkg::OP_SUB,  MAXV, MAXV, MAXV, MAXV);
    send_ops(cau_pkg::OP_MUL,  MAXV, MAXV, MAXV, MAXV);
    send_ops(cau_pkg::OP_MUL,  MINV, MINV, MINV, MINV);
    send_ops(cau_pkg::OP_MUL,  ONE + 1, -ONE, -3, ONE);
    send_ops(cau_pkg::OP_DIV,  ONE, ONE, 0, 0);
    send_ops(cau_pkg::OP_DIV,  MINV, MAXV, 1, 0);
    send_ops(cau_pkg::OP_DIV,  ONE, 0, 3 * ONE, 0);
    send_ops(cau_pkg::OP_DIV,  MINV, MINV, MINV, MINV);
    send_ops(cau_pkg::OP_CONJ, MINV, MINV, MAXV, MAXV);
    send_ops(cau_pkg::OP_CONJ, MAXV, MAXV, 0, 0);
    send_ops(cau_pkg::OP_MOD,  MINV, MINV, 0, 0);
    send_ops(cau_pkg::OP_MOD,  3 * ONE, 4 * ONE, 0, 0);
    send_ops(cau_pkg::OP_ARG,  0, 0, 0, 0);
    send_ops(cau_pkg::OP_ARG,  -ONE, 0, 0, 0);
    send_ops(cau_pkg::OP_ARG,  -ONE, ONE, 0, 0);
    send_ops(cau_pkg::OP_ARG,  -ONE, -ONE, 0, 0);
    send_ops(cau_pkg::OP_ARG,  0, MINV, 0, 0);
    send_ops(cau_pkg::OP_ARG,  MAXV, -1, 0, 0);
    send_ops(cau_pkg::OP_EQ,   MINV, MAXV, MINV, MAXV);
    send_ops(cau_pkg::OP_EQ,   MINV, MAXV, MINV, MAXV - 1);
    send_ops(cau_pkg::OP_EQ,   0, 0, 1, 0);

    // Let the pipeline empty once with the source held off
    drain();

    // Random mix; compare gets equal operands and divide a zero denominator now and then
    for (int n = 0; n < N_RANDOM + N_QUIET; n++) begin
      if (n == N_RANDOM) begin
        drain();
        quiet = 1;
      end
      o.opcode = $urandom_range(0, 7);
      o.a_re = pick_value();
      o.a_im = pick_value();
      o.b_re = pick_value();
      o.b_im = pick_value();
      if (o.opcode == cau_pkg::OP_EQ && $urandom_range(0, 1)) begin
        o.b_re = o.a_re;
        o.b_im = o.a_im;
      end
      if (o.opcode == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0) begin
        o.b_re = 0;
        o.b_im = 0;
      end
      send(o);
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk);

    $display("Ran %0d results: add %0d sub %0d mul %0d div %0d conj %0d",
             sb.checked, sb.op_count[cau_pkg::OP_ADD], sb.op_count[cau_pkg::OP_SUB],
             sb.op_count[cau_pkg::OP_MUL], sb.op_count[cau_pkg::OP_DIV],
             sb.op_count[cau_pkg::OP_CONJ]);
    $display("  modulus %0d argument %0d compare %0d, mismatches %0d",
             sb.op_count[cau_pkg::OP_MOD], sb.op_count[cau_pkg::OP_ARG],
             sb.op_count[cau_pkg::OP_EQ], sb.mismatches);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("complex_arithmetic_unit verification clean");
    end else begin
      $display("complex_arithmetic_unit verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cau_pkg.sv
rtl/core/cau_if.sv
rtl/core/cau_front.sv
rtl/core/cau_back.sv
rtl/core/complex_arithmetic_unit.sv
verif/tb_complex_arithmetic_unit.sv
